// ===== sv/drprl_pkg.sv =====
// Package for the delayed relay pair with reclose lockout.
// Holds the request codes, register indexes and reset constants; no dependencies.
`default_nettype none

package drprl_pkg;

  localparam int unsigned NUM_RELAYS_DEF  = 2;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned FIELD_WIDTH = 16;

  typedef enum logic [1:0] {
    CMD_ON   = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_TIME = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_RECLOSE_TICKS  = 1'b0,
    REG_TICK_PERIOD_MS = 1'b1
  } reg_index_t;

  localparam logic [FIELD_WIDTH-1:0] RECLOSE_TICKS_RESET  = 16'd20;
  localparam logic [FIELD_WIDTH-1:0] TICK_PERIOD_MS_RESET = 16'd100;

endpackage

`default_nettype wire

// ===== sv/delayed_relay_pair_with_reclose_lockout.sv =====
// Delayed relay pair with reclose lockout: top level, depends on drprl_pkg.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle; in_stall rises only while a result waits under out_stall.
// The relay state is updated at the accepting edge and the result is registered with it.
// Reset (rst, synchronous, active high) clears the relay state, the start flag,
// the output valid and sets both registers to their reset values.
`default_nettype none

module delayed_relay_pair_with_reclose_lockout #(
  parameter int unsigned NUM_RELAYS  = drprl_pkg::NUM_RELAYS_DEF,
  parameter int unsigned COUNT_WIDTH = drprl_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic        relay_select,
  input  wire logic [15:0] delay_ticks,
  input  wire logic [15:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             relay_a_on,
  output logic             relay_b_on,
  output logic             tick_applied,
  output logic             relay_a_locked,
  output logic             relay_b_locked
);

  logic [15:0] reclose_ticks;
  logic [15:0] tick_period_ms;

  logic        started;
  logic        started_next;
  logic [15:0] last_tick_ms;
  logic [15:0] last_tick_ms_next;

  logic [NUM_RELAYS-1:0]  requested_on;
  logic [NUM_RELAYS-1:0]  requested_on_next;
  logic [COUNT_WIDTH-1:0] on_countdown           [NUM_RELAYS];
  logic [COUNT_WIDTH-1:0] on_countdown_next      [NUM_RELAYS];
  logic [COUNT_WIDTH-1:0] off_countdown          [NUM_RELAYS];
  logic [COUNT_WIDTH-1:0] off_countdown_next     [NUM_RELAYS];
  logic [COUNT_WIDTH-1:0] lockout_countdown      [NUM_RELAYS];
  logic [COUNT_WIDTH-1:0] lockout_countdown_next [NUM_RELAYS];
  logic [NUM_RELAYS-1:0]  reclose_allowed;
  logic [NUM_RELAYS-1:0]  reclose_allowed_next;
  logic [NUM_RELAYS-1:0]  drive_level;
  logic [NUM_RELAYS-1:0]  drive_level_next;

  logic                   accept;
  logic                   is_on;
  logic                   is_off;
  logic                   is_time;
  logic                   tick;
  logic [15:0]            elapsed;
  logic [COUNT_WIDTH-1:0] delay_c;
  logic [COUNT_WIDTH-1:0] reclose_c;
  logic                   b_on_next;
  logic                   b_locked_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_on   = (cmd == drprl_pkg::CMD_ON);
  assign is_off  = (cmd == drprl_pkg::CMD_OFF);
  assign is_time = (cmd == drprl_pkg::CMD_TIME);

  assign elapsed   = now_ms - last_tick_ms;
  assign tick      = is_time && started && (elapsed >= tick_period_ms);
  assign delay_c   = COUNT_WIDTH'(delay_ticks);
  assign reclose_c = COUNT_WIDTH'(reclose_ticks);

  assign started_next      = started || is_time;
  assign last_tick_ms_next = tick ? now_ms : last_tick_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      reclose_ticks  <= drprl_pkg::RECLOSE_TICKS_RESET;
      tick_period_ms <= drprl_pkg::TICK_PERIOD_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        drprl_pkg::REG_RECLOSE_TICKS:  reclose_ticks  <= cfg_data;
        drprl_pkg::REG_TICK_PERIOD_MS: tick_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < NUM_RELAYS; r++) begin : g_relay
    logic hit;

    assign hit = (int'(relay_select) == r);

    always_comb begin
      requested_on_next[r]      = requested_on[r];
      on_countdown_next[r]      = on_countdown[r];
      off_countdown_next[r]     = off_countdown[r];
      lockout_countdown_next[r] = lockout_countdown[r];
      reclose_allowed_next[r]   = reclose_allowed[r];
      drive_level_next[r]       = drive_level[r];
      if (is_on && hit && !requested_on[r]) begin
        requested_on_next[r] = 1'b1;
        on_countdown_next[r] = delay_c;
      end else if (is_off && hit && requested_on[r]) begin
        lockout_countdown_next[r] = reclose_c;
        reclose_allowed_next[r]   = 1'b0;
        requested_on_next[r]      = 1'b0;
        off_countdown_next[r]     = delay_c;
      end else if (tick) begin
        if (requested_on[r]) begin
          if (on_countdown[r] != '0) begin
            on_countdown_next[r] = on_countdown[r] - 1'b1;
          end else if (reclose_allowed[r]) begin
            drive_level_next[r] = 1'b1;
          end
        end else begin
          if (off_countdown[r] != '0) begin
            off_countdown_next[r] = off_countdown[r] - 1'b1;
          end else begin
            drive_level_next[r] = 1'b0;
          end
        end
        if (lockout_countdown[r] != '0) begin
          lockout_countdown_next[r] = lockout_countdown[r] - 1'b1;
        end else begin
          reclose_allowed_next[r] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        requested_on[r]      <= 1'b0;
        on_countdown[r]      <= '0;
        off_countdown[r]     <= '0;
        lockout_countdown[r] <= '0;
        reclose_allowed[r]   <= 1'b1;
        drive_level[r]       <= 1'b0;
      end else if (accept) begin
        requested_on[r]      <= requested_on_next[r];
        on_countdown[r]      <= on_countdown_next[r];
        off_countdown[r]     <= off_countdown_next[r];
        lockout_countdown[r] <= lockout_countdown_next[r];
        reclose_allowed[r]   <= reclose_allowed_next[r];
        drive_level[r]       <= drive_level_next[r];
      end
    end
  end

  if (NUM_RELAYS > 1) begin : g_b
    assign b_on_next     = drive_level_next[1];
    assign b_locked_next = !reclose_allowed_next[1];
  end else begin : g_no_b
    assign b_on_next     = 1'b0;
    assign b_locked_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      last_tick_ms <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        started      <= started_next;
        last_tick_ms <= last_tick_ms_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      relay_a_on     <= drive_level_next[0];
      relay_b_on     <= b_on_next;
      tick_applied   <= tick;
      relay_a_locked <= !reclose_allowed_next[0];
      relay_b_locked <= b_locked_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/drprl_checker.sv =====
// Port-level checker for the delayed relay pair with reclose lockout.
// Depends on drprl_pkg and is bound to the top level at the end of this file.
`default_nettype none

module drprl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        tick_applied
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid straight after reset.");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("Accepted request produced no result.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output register could take a result.");

  a_tick_only_for_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd != drprl_pkg::CMD_TIME) |=> !tick_applied)
    else $error("Tick reported for a switching request.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("Stalled result dropped.");

endmodule

bind delayed_relay_pair_with_reclose_lockout drprl_checker u_drprl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .cmd          (cmd),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .tick_applied (tick_applied)
);

`default_nettype wire

// ===== bench/drprl_status_checker.sv =====
// Status checker for the delayed relay pair: watches the register port and both channels,
// predicts the status for every accepted request and compares it with what the block returns.
// Depends on drprl_pkg for the request codes and register indexes.
`default_nettype none

module drprl_status_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic        relay_select,
  input  wire logic [15:0] delay_ticks,
  input  wire logic [15:0] now_ms,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        relay_a_on,
  input  wire logic        relay_b_on,
  input  wire logic        tick_applied,
  input  wire logic        relay_a_locked,
  input  wire logic        relay_b_locked,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic a_on;
    logic b_on;
    logic tick;
    logic a_locked;
    logic b_locked;
  } status_word_t;

  logic [15:0]   reclose_len;
  logic [15:0]   period_ms;
  logic          running;
  logic [15:0]   last_tick;
  logic [1:0]    want_on;
  logic [15:0]   on_left   [2];
  logic [15:0]   off_left  [2];
  logic [15:0]   lock_left [2];
  logic [1:0]    may_close;
  logic [1:0]    level;
  status_word_t  status_q [$];
  int            errs  = 0;
  int            depth = 0;

  assign mismatches = errs;
  assign pending    = depth;

  task automatic tick_relays();
    for (int r = 0; r < 2; r++) begin
      if (want_on[r]) begin
        if (on_left[r] != 16'd0) on_left[r] = on_left[r] - 16'd1;
        else if (may_close[r]) level[r] = 1'b1;
      end else begin
        if (off_left[r] != 16'd0) off_left[r] = off_left[r] - 16'd1;
        else level[r] = 1'b0;
      end
      if (lock_left[r] != 16'd0) lock_left[r] = lock_left[r] - 16'd1;
      else may_close[r] = 1'b1;
    end
  endtask

  task automatic apply_request(input logic [1:0] c, input logic sel, input logic [15:0] delay,
                               input logic [15:0] now, output status_word_t st);
    logic        ticked;
    logic [15:0] since;
    ticked = 1'b0;
    since  = now - last_tick;
    if (c == drprl_pkg::CMD_ON) begin
      if (!want_on[sel]) begin
        want_on[sel] = 1'b1;
        on_left[sel] = delay;
      end
    end else if (c == drprl_pkg::CMD_OFF) begin
      if (want_on[sel]) begin
        lock_left[sel] = reclose_len;
        may_close[sel] = 1'b0;
        want_on[sel]   = 1'b0;
        off_left[sel]  = delay;
      end
    end else if (c == drprl_pkg::CMD_TIME) begin
      if (!running) begin
        running = 1'b1;
      end else if (since >= period_ms) begin
        last_tick = now;
        tick_relays();
        ticked = 1'b1;
      end
    end
    st.a_on     = level[0];
    st.b_on     = level[1];
    st.tick     = ticked;
    st.a_locked = !may_close[0];
    st.b_locked = !may_close[1];
  endtask

  function automatic int field_differs(string name, logic want_bit, logic got_bit);
    if (got_bit !== want_bit) begin
      $error("%s expected %0b got %0b", name, want_bit, got_bit);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    status_word_t want;
    status_word_t next_status;
    if (rst) begin
      reclose_len = drprl_pkg::RECLOSE_TICKS_RESET;
      period_ms   = drprl_pkg::TICK_PERIOD_MS_RESET;
      running     = 1'b0;
      last_tick   = 16'd0;
      want_on     = 2'b00;
      may_close   = 2'b11;
      level       = 2'b00;
      for (int r = 0; r < 2; r++) begin
        on_left[r]   = 16'd0;
        off_left[r]  = 16'd0;
        lock_left[r] = 16'd0;
      end
      status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == drprl_pkg::REG_RECLOSE_TICKS) reclose_len = cfg_data;
        else period_ms = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("status returned with no request outstanding");
          errs++;
        end else begin
          want = status_q.pop_front();
          errs += field_differs("relay_a_on", want.a_on, relay_a_on);
          errs += field_differs("relay_b_on", want.b_on, relay_b_on);
          errs += field_differs("tick_applied", want.tick, tick_applied);
          errs += field_differs("relay_a_locked", want.a_locked, relay_a_locked);
          errs += field_differs("relay_b_locked", want.b_locked, relay_b_locked);
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(cmd, relay_select, delay_ticks, now_ms, next_status);
        status_q.push_back(next_status);
      end
    end
    depth = status_q.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_delayed_relay_pair_with_reclose_lockout.sv =====
// Testbench top for the delayed relay pair: drives requests and register writes, stalls the
// result side at random and gives the verdict. Depends on drprl_pkg, the block and
// drprl_status_checker, which predicts and compares every status.
`default_nettype none

module tb_delayed_relay_pair_with_reclose_lockout;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         QUIET_LIMIT = 5000;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 285;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic        relay_select;
  logic [15:0] delay_ticks;
  logic [15:0] now_ms;
  logic        out_valid;
  logic        out_stall;
  logic        relay_a_on;
  logic        relay_b_on;
  logic        tick_applied;
  logic        relay_a_locked;
  logic        relay_b_locked;
  int          mismatches;
  int          pending;

  int          send_pct;
  int          recv_pct;
  int          period_now;
  int          quiet = 0;
  logic [15:0] clock_ms;

  delayed_relay_pair_with_reclose_lockout dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .relay_select(relay_select), .delay_ticks(delay_ticks), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .relay_a_on(relay_a_on), .relay_b_on(relay_b_on), .tick_applied(tick_applied),
    .relay_a_locked(relay_a_locked), .relay_b_locked(relay_b_locked)
  );

  drprl_status_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .relay_select(relay_select), .delay_ticks(delay_ticks), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .relay_a_on(relay_a_on), .relay_b_on(relay_b_on), .tick_applied(tick_applied),
    .relay_a_locked(relay_a_locked), .relay_b_locked(relay_b_locked),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Called at a falling edge; returns at a falling edge after the request is taken.
  task automatic send_request(input logic [1:0] c, input logic sel, input logic [15:0] delay,
                              input logic [15:0] now);
    in_valid     <= 1'b1;
    cmd          <= c;
    relay_select <= sel;
    delay_ticks  <= delay;
    now_ms       <= now;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input drprl_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request();
    int          pick;
    int          step;
    logic [15:0] delay;
    pick  = $urandom_range(99);
    delay = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 6)) : 16'($urandom);
    if (pick < 48) begin
      if ($urandom_range(9) < 7) step = period_now + $urandom_range(0, 4) - 2;
      else step = $urandom_range(0, 2 * period_now);
      clock_ms = clock_ms + 16'(step);
      send_request(drprl_pkg::CMD_TIME, 1'($urandom), 16'($urandom), clock_ms);
    end else if (pick < 53) begin
      send_request(drprl_pkg::CMD_TIME, 1'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 73) begin
      send_request(drprl_pkg::CMD_ON, 1'($urandom), delay, 16'($urandom));
    end else if (pick < 93) begin
      send_request(drprl_pkg::CMD_OFF, 1'($urandom), delay, 16'($urandom));
    end else begin
      send_request(CMD_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] reclose_v;
    logic [15:0] period_v;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = drprl_pkg::REG_RECLOSE_TICKS;
    cfg_data     = 16'd0;
    in_valid     = 1'b0;
    cmd          = drprl_pkg::CMD_ON;
    relay_select = 1'b0;
    delay_ticks  = 16'd0;
    now_ms       = 16'd0;
    out_stall    = 1'b0;
    send_pct     = 18;
    recv_pct     = 52;
    period_now   = 100;
    clock_ms     = 16'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first time stamp only starts the block; then walk one relay through a
    // lockout and check the wrapped time difference.
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'hFFFF);
    send_request(drprl_pkg::CMD_TIME, 1'b1, 16'hFFFF, 16'h0064);
    send_request(CMD_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF);
    send_request(drprl_pkg::CMD_ON, 1'b0, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_ON, 1'b0, 16'hFFFF, 16'hFFFF);
    send_request(drprl_pkg::CMD_OFF, 1'b1, 16'hFFFF, 16'h0000);
    send_request(drprl_pkg::CMD_ON, 1'b1, 16'h0001, 16'h0000);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h00C7);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h00C8);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h012C);
    send_request(drprl_pkg::CMD_OFF, 1'b0, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_ON, 1'b0, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h0190);
    send_request(drprl_pkg::CMD_OFF, 1'b1, 16'h0002, 16'h0000);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'hFFF0);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h0054);
    drain();
    write_reg(drprl_pkg::REG_TICK_PERIOD_MS, 16'd0);
    write_reg(drprl_pkg::REG_RECLOSE_TICKS, 16'd0);
    period_now = 0;
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h0054);
    send_request(drprl_pkg::CMD_TIME, 1'b1, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_OFF, 1'b0, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_TIME, 1'b0, 16'h0000, 16'h0000);
    send_request(drprl_pkg::CMD_ON, 1'b1, 16'hFFFF, 16'h0000);
    clock_ms = 16'h0000;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin reclose_v = 16'd3;     period_v = 16'd100;   end
        1:       begin reclose_v = 16'd0;     period_v = 16'd1;     end
        2:       begin reclose_v = 16'd65535; period_v = 16'd65535; end
        3:       begin reclose_v = 16'd5;     period_v = 16'd37;    end
        4:       begin reclose_v = 16'd1;     period_v = 16'd250;   end
        default: begin reclose_v = 16'd10;    period_v = 16'd2;     end
      endcase
      send_pct = (phase < 2) ? 18 : (phase < 4) ? 52 : 0;
      recv_pct = (phase < 2) ? 52 : (phase < 4) ? 18 : 0;
      drain();
      write_reg(drprl_pkg::REG_RECLOSE_TICKS, reclose_v);
      write_reg(drprl_pkg::REG_TICK_PERIOD_MS, period_v);
      period_now = int'(period_v);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 140) drain();
        random_request();
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
